>>> hw/rtl/vsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsd_pkg
// Shared constants and types for the streaming LEB128 varint decoder.
// ----------------------------------------------------------------------------
package vsd_pkg;

    // Byte layout: bit 7 is the continuation flag, bits 6..0 the payload.
    localparam int unsigned ByteW    = 8;
    localparam int unsigned PayloadW = 7;
    localparam int unsigned ContBit  = 7;

    // Decoded value and byte counter widths.
    localparam int unsigned ValueW = 64;
    localparam int unsigned CountW = 4;
    localparam int unsigned ShiftW = 7;

    // Byte limits for the two modes.
    localparam logic [CountW-1:0] IntLimit  = 4'd5;
    localparam logic [CountW-1:0] LongLimit = 4'd10;

    // One decoded number as it travels to the result register.
    typedef struct packed {
        logic [ValueW-1:0] value;
        logic [CountW-1:0] byte_count;
        logic              overlong;
    } t_result;

endpackage

>>> hw/rtl/vsd_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsd_accum
// Accumulator and byte counter; merges one byte per cycle while i_process is high and decides
// whether the byte ends the current number.
// ----------------------------------------------------------------------------
module vsd_accum (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_process,
    input  logic [vsd_pkg::ByteW-1:0]      i_byte,
    input  logic                           i_long_mode,
    output logic                           o_end,
    output vsd_pkg::t_result               o_result
);

    logic [vsd_pkg::ValueW-1:0] r_acc;
    logic [vsd_pkg::ValueW-1:0] n_acc;
    logic [vsd_pkg::CountW-1:0] r_seen;
    logic [vsd_pkg::CountW-1:0] n_seen;

    logic [vsd_pkg::ShiftW-1:0] shift;
    logic [vsd_pkg::ValueW-1:0] placed;
    logic [vsd_pkg::ValueW-1:0] merged;
    logic [vsd_pkg::CountW-1:0] count;
    logic [vsd_pkg::CountW-1:0] limit;
    logic                       over;

    // Bit position of this byte's payload: seven times the byte index.
    assign shift = {r_seen, 3'b000} - {3'b000, r_seen};

    // Payload placed at its position; positions at or beyond 64 add nothing.
    always_comb begin
        placed = '0;
        if (shift < vsd_pkg::ShiftW'(vsd_pkg::ValueW)) begin
            placed = {{(vsd_pkg::ValueW-vsd_pkg::PayloadW){1'b0}},
                      i_byte[vsd_pkg::PayloadW-1:0]} << shift;
        end
    end

    assign merged = r_acc | placed;
    assign count  = r_seen + 4'd1;
    assign limit  = i_long_mode ? vsd_pkg::LongLimit : vsd_pkg::IntLimit;
    assign over   = count > limit;

    // A clear continuation flag or a byte past the limit ends the number.
    assign o_end = over || !i_byte[vsd_pkg::ContBit];

    // Result fields, with the value cut to 32 bits in VarInt mode.
    always_comb begin
        o_result.value      = i_long_mode ? merged : {32'd0, merged[31:0]};
        o_result.byte_count = count;
        o_result.overlong   = over;
    end

    // State update for a processed byte.
    always_comb begin
        n_acc  = r_acc;
        n_seen = r_seen;
        if (i_process) begin
            if (o_end) begin
                n_acc  = '0;
                n_seen = '0;
            end else begin
                n_acc  = merged;
                n_seen = count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_seen <= '0;
        end else begin
            r_acc  <= n_acc;
            r_seen <= n_seen;
        end
    end

    // The byte counter never passes the larger limit.
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= vsd_pkg::LongLimit)
        else $error("byte counter beyond the VarLong limit");

    // A finished number leaves the state cleared.
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_process && o_end |=> r_seen == '0 && r_acc == '0)
        else $error("state not cleared after a number ended");

    // A continuing byte advances the counter by one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_process && !o_end |=> r_seen == $past(r_seen) + 4'd1)
        else $error("byte counter did not advance");

    // An overlong number always has more bytes than the VarInt limit.
    a_overlong_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.overlong |-> o_result.byte_count > vsd_pkg::IntLimit)
        else $error("overlong flagged below the byte limit");

endmodule

>>> hw/rtl/vsd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsd_out_reg
// Result register on the output channel; holds a result until its transfer.
// ----------------------------------------------------------------------------
module vsd_out_reg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  vsd_pkg::t_result                i_result,
    output logic                            o_ready,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [vsd_pkg::ValueW-1:0]      o_value,
    output logic [vsd_pkg::CountW-1:0]      o_byte_count,
    output logic                            o_overlong
);

    logic             r_vld;
    logic             n_vld;
    vsd_pkg::t_result r_res;

    // The register can take a new result when empty or emptying this cycle.
    assign o_ready = !r_vld || !i_stall;

    always_comb begin
        n_vld = r_vld;
        if (o_ready) begin
            n_vld = i_load;
        end
    end

    // Valid flag under reset; the payload needs none.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_res <= i_result;
        end
    end

    assign o_valid      = r_vld;
    assign o_value      = r_res.value;
    assign o_byte_count = r_res.byte_count;
    assign o_overlong   = r_res.overlong;

endmodule

>>> hw/rtl/varint_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_stream_decoder
// Streaming unsigned LEB128 varint decoder, one byte per transfer.
// ----------------------------------------------------------------------------
// Path: a terminating byte's result passes through the input register, then
// the result register. Throughput: one byte per cycle, but a terminating byte
// waits while the result register cannot take its result.
// Reset (synchronous, active low) clears the accumulator, the byte counter,
// the valid flags and the mode register (VarInt mode).
// ----------------------------------------------------------------------------
module varint_stream_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_wr_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [vsd_pkg::ByteW-1:0]       i_data_byte,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [vsd_pkg::ValueW-1:0]      o_value,
    output logic [vsd_pkg::CountW-1:0]      o_byte_count,
    output logic                            o_overlong
);

    logic                       r_long_mode;
    logic                       r_in_vld;
    logic [vsd_pkg::ByteW-1:0]  r_in_byte;
    logic                       num_end;
    logic                       out_ready;
    logic                       advance;
    vsd_pkg::t_result           result;

    // Mode register; the user must write it only while the block is idle, which the block itself does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_long_mode <= i_cfg_wr_data;
        end
    end

    // A held byte moves on unless it ends a number and the result register cannot take it.
    assign advance = r_in_vld && (!num_end || out_ready);
    assign o_stall = r_in_vld && !advance;

    // Input register: refilled on every cycle in which it is not stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    vsd_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_process   (advance),
        .i_byte      (r_in_byte),
        .i_long_mode (r_long_mode),
        .o_end       (num_end),
        .o_result    (result)
    );

    vsd_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (advance && num_end),
        .i_result     (result),
        .o_ready      (out_ready),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_value      (o_value),
        .o_byte_count (o_byte_count),
        .o_overlong   (o_overlong)
    );

endmodule

>>> sim/tb_varint_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_varint_stream_decoder
// Self-checking testbench for the streaming LEB128 varint decoder.
// A queue of raw bytes feeds a clocked driver. Each accepted byte is decoded by
// a local model of the decoder, and the numbers it completes wait in a queue of
// expected results. A clocked monitor takes the results under random stall and
// compares every field. The run starts with directed numbers: single-byte
// extremes, full-width values, truncation and overlong cases. It then sends
// random numbers in both modes, switches the mode part-way through a number, and
// varies the idling of both sides between phases.
// ----------------------------------------------------------------------------
module tb_varint_stream_decoder;

    localparam int unsigned CycleLimit = 200000;

    // Clock, reset and block ports; every input starts at a known value.
    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic                         cfg_wr_data = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [vsd_pkg::ByteW-1:0]    data_byte = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [vsd_pkg::ValueW-1:0]   value;
    logic [vsd_pkg::CountW-1:0]   byte_count;
    logic                         overlong;

    // Stimulus and prediction state.
    logic [vsd_pkg::ByteW-1:0]    byte_q[$];
    vsd_pkg::t_result             expected_numbers[$];
    logic [vsd_pkg::ValueW-1:0]   acc_bits = '0;
    logic [vsd_pkg::CountW-1:0]   bytes_held = '0;
    logic                         decode_long = 1'b0;
    int unsigned                  send_idle_pct = 0;
    int unsigned                  recv_idle_pct = 0;
    int unsigned                  errors = 0;
    int unsigned                  cycle_count = 0;

    varint_stream_decoder uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_data_byte   (data_byte),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_value       (value),
        .o_byte_count  (byte_count),
        .o_overlong    (overlong)
    );

    // 8 ns clock.
    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Decodes one accepted byte and queues the number it completes, if any.
    function automatic void decode_byte(input logic [vsd_pkg::ByteW-1:0] b);
        int unsigned                 shift_amt;
        logic [vsd_pkg::CountW:0]    count;
        logic                        over;
        vsd_pkg::t_result            number;
        shift_amt = int'(bytes_held) * vsd_pkg::PayloadW;
        if (shift_amt < vsd_pkg::ValueW) begin
            acc_bits = acc_bits |
                       (vsd_pkg::ValueW'(b[vsd_pkg::PayloadW-1:0]) << shift_amt);
        end
        count = {1'b0, bytes_held} + 1'b1;
        over  = count > {1'b0, (decode_long ? vsd_pkg::LongLimit : vsd_pkg::IntLimit)};
        if (!over && b[vsd_pkg::ContBit]) begin
            bytes_held = count[vsd_pkg::CountW-1:0];
        end else begin
            number.value      = decode_long ? acc_bits :
                                vsd_pkg::ValueW'(acc_bits[31:0]);
            number.byte_count = count[vsd_pkg::CountW-1:0];
            number.overlong   = over;
            expected_numbers.push_back(number);
            acc_bits   = '0;
            bytes_held = '0;
        end
    endfunction

    // Driver: presents queued bytes, holding each one until its transfer.
    always @(posedge clk) begin : driver
        logic present;
        if (!rst_n) begin
            in_valid  <= 1'b0;
            data_byte <= '0;
        end else begin
            if (in_valid && !in_stall) begin
                decode_byte(data_byte);
            end
            if (!in_valid || !in_stall) begin
                present = (byte_q.size() > 0) && ($urandom_range(99) >= send_idle_pct);
                if (present) begin
                    in_valid  <= 1'b1;
                    data_byte <= byte_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stall, and a field-by-field check of every result transfer.
    always @(posedge clk) begin : monitor
        vsd_pkg::t_result want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_numbers.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result value=%h count=%0d overlong=%b",
                             $time, value, byte_count, overlong);
                end else begin
                    want = expected_numbers.pop_front();
                    if (value !== want.value || byte_count !== want.byte_count ||
                        overlong !== want.overlong) begin
                        errors++;
                        $display({"%0t: mismatch value exp=%h act=%h, ",
                                  "count exp=%0d act=%0d, overlong exp=%b act=%b"},
                                 $time, want.value, value, want.byte_count, byte_count,
                                 want.overlong, overlong);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Waits until every queued byte has gone and every expected result has come,
    // then lets the pipeline settle for bytes that produce no result.
    task automatic drain();
        wait (byte_q.size() == 0 && !in_valid && expected_numbers.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    // Mode register write; only called while the decoder is idle.
    task automatic set_mode(input logic long_sel);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= long_sel;
        decode_long = long_sel;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Queues a number of len bytes with random payloads. All bytes but the last
    // carry the continuation flag; the last one carries last_cont.
    task automatic push_number(input int unsigned len, input logic last_cont);
        logic [vsd_pkg::ByteW-1:0] b;
        for (int unsigned i = 0; i < len; i++) begin
            b = vsd_pkg::ByteW'($urandom_range(255));
            b[vsd_pkg::ContBit] = (i < len - 1) ? 1'b1 : last_cont;
            byte_q.push_back(b);
        end
    endtask

    // Mostly well-formed numbers, some overlong ones and some raw noise bytes.
    task automatic fill_random(input int unsigned target);
        int unsigned pushed;
        int unsigned pick;
        int unsigned len;
        int unsigned lim;
        pushed = 0;
        lim = 32'(decode_long ? vsd_pkg::LongLimit : vsd_pkg::IntLimit);
        while (pushed < target) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(lim, 1) : $urandom_range(3, 1);
                push_number(len, 1'b0);
            end else if (pick < 87) begin
                len = lim + 1;
                push_number(len, 1'(($urandom_range(1))));
            end else begin
                len = 1;
                byte_q.push_back(vsd_pkg::ByteW'($urandom_range(255)));
            end
            pushed += len;
        end
    endtask

    // Watchdog.
    initial begin
        wait (cycle_count >= CycleLimit);
        $display("FAIL varint_stream_decoder");
        $finish;
    end

    // Stimulus sequence.
    initial begin
        send_idle_pct = 34;
        recv_idle_pct = 70;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_mode(1'b0);

        // VarInt: smallest and largest single byte, all-ones 32-bit value,
        // a zero value that runs past the five-byte limit.
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h7f);
        repeat (4) byte_q.push_back(8'hff);
        byte_q.push_back(8'h7f);
        repeat (5) byte_q.push_back(8'h80);
        byte_q.push_back(8'h00);
        drain();

        // VarLong: all-ones 64-bit value, with payload bits above bit 63 dropped.
        set_mode(1'b1);
        repeat (9) byte_q.push_back(8'hff);
        byte_q.push_back(8'h7f);
        drain();

        // First random phase, with a full pause half-way; it ends part-way
        // through a number, which then continues under the longer limit.
        set_mode(1'b0);
        fill_random(160);
        drain();
        fill_random(160);
        push_number(3, 1'b1);
        drain();
        set_mode(1'b1);

        // Second phase in VarLong; ten continuation bytes are left pending, so the
        // switch to VarInt makes the next byte end the number as overlong.
        send_idle_pct = 70;
        recv_idle_pct = 34;
        fill_random(320);
        push_number(10, 1'b1);
        drain();
        set_mode(1'b0);

        // Last phase at full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fill_random(300);
        drain();
        repeat (10) @(posedge clk);

        if (errors == 0 && expected_numbers.size() == 0) begin
            $display("PASS varint_stream_decoder");
        end else begin
            $display("FAIL varint_stream_decoder");
        end
        $finish;
    end

endmodule

>>> varint_stream_decoder.f
hw/rtl/vsd_pkg.sv
hw/rtl/vsd_accum.sv
hw/rtl/vsd_out_reg.sv
hw/rtl/varint_stream_decoder.sv
sim/tb_varint_stream_decoder.sv
